// ===== rtl/sonar_outlier_average_filter_macros.svh =====
// Assertion macros used by the checker file.
`ifndef SONAR_OUTLIER_AVERAGE_FILTER_MACROS_SVH
`define SONAR_OUTLIER_AVERAGE_FILTER_MACROS_SVH

// Checked on every clock edge outside reset.
`define SOFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define SOFA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/sofa_pkg.sv =====
// Constants and types shared by the outlier-rejecting average filter.
`default_nettype none
package sofa_pkg;

  localparam int SAMPLES = 8;

  localparam int IDX_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam int SUM_W = $clog2(SAMPLES * 255 + 1);
  localparam int ALU_W = (SUM_W > 9) ? SUM_W : 9;
  localparam int REJ_W = 9;
  localparam int ADDR_W = 4;

  localparam logic [1:0] REG_MAX_VALID      = 2'd0;
  localparam logic [1:0] REG_MAX_REJECTS    = 2'd1;
  localparam logic [1:0] REG_OUTLIER_OFFSET = 2'd2;

  localparam logic [8:0] MAX_VALID_RST      = 9'd255;
  localparam logic [7:0] MAX_REJECTS_RST    = 8'd10;
  localparam logic [7:0] OUTLIER_OFFSET_RST = 8'd20;

  localparam logic [7:0] FAIL_ALTITUDE = 8'd255;

  typedef struct packed {
    logic [8:0] max_valid;
    logic [7:0] max_rejects;
    logic [7:0] outlier_offset;
  } cfg_t;

  typedef struct packed {
    logic [7:0] altitude;
    logic       failed;
  } res_t;

endpackage
`default_nettype wire

// ===== rtl/sonar_outlier_average_filter.sv =====
// Top level of the outlier-rejecting average filter for a sonar range sensor.
// Each 12-bit sample is scaled to 8 bits (>> 4); values at or above max_valid
// are rejected and counted, and once the reject count exceeds max_rejects a
// failure item (altitude 255, failed 1) is sent and the window restarts.
// Good values are written to an 8-deep sample store. The sample that completes
// the window starts a pass: the mean and limit are formed first, then each
// stored value goes in turn through the single read port of the store and the
// shared adder/comparator, while in_stall is high. A result waits in an output
// register; outside the mean step and the pass the block stalls only if a new
// result is due while one still waits. Registers: max_valid at 0x0,
// max_rejects at 0x4, outlier_offset at 0x8.
`default_nettype none
module sonar_outlier_average_filter (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         in_valid,
  output logic                        in_stall,
  input  wire  [11:0]                 adc_sample,
  output logic                        out_valid,
  input  wire                         out_stall,
  output logic [7:0]                  altitude,
  output logic                        failed,
  input  wire                         psel,
  input  wire                         penable,
  input  wire                         pwrite,
  input  wire  [sofa_pkg::ADDR_W-1:0] paddr,
  input  wire  [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import sofa_pkg::*;

  cfg_t              cfg;
  res_t              res;
  logic              res_load;
  logic              slot_free;
  logic              cfg_wr;
  logic [1:0]        reg_idx;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_valid      <= MAX_VALID_RST;
      cfg.max_rejects    <= MAX_REJECTS_RST;
      cfg.outlier_offset <= OUTLIER_OFFSET_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_MAX_VALID:      cfg.max_valid      <= pwdata[8:0];
        REG_MAX_REJECTS:    cfg.max_rejects    <= pwdata[7:0];
        REG_OUTLIER_OFFSET: cfg.outlier_offset <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MAX_VALID:      prdata = {23'd0, cfg.max_valid};
      REG_MAX_REJECTS:    prdata = {24'd0, cfg.max_rejects};
      REG_OUTLIER_OFFSET: prdata = {24'd0, cfg.outlier_offset};
      default:            prdata = '0;
    endcase
  end

  assign slot_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
      altitude  <= res.altitude;
      failed    <= res.failed;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  sofa_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .adc_sample (adc_sample),
    .in_stall   (in_stall),
    .cfg        (cfg),
    .slot_free  (slot_free),
    .res_load   (res_load),
    .res        (res),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata)
  );

  sofa_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
`default_nettype wire

// ===== rtl/sofa_ram.sv =====
// Sample store: one write port, one registered read port.
`default_nettype none
module sofa_ram (
  input  wire                       clk,
  input  wire                       we,
  input  wire  [sofa_pkg::IDX_W-1:0] waddr,
  input  wire  [7:0]                wdata,
  input  wire  [sofa_pkg::IDX_W-1:0] raddr,
  output logic [7:0]                rdata
);
  import sofa_pkg::*;

  logic [7:0] mem [SAMPLES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/sofa_alu.sv =====
// Shared adder and magnitude comparator.
`default_nettype none
module sofa_alu (
  input  wire  [sofa_pkg::ALU_W-1:0] add_a,
  input  wire  [sofa_pkg::ALU_W-1:0] add_b,
  input  wire  [sofa_pkg::ALU_W-1:0] cmp_a,
  input  wire  [sofa_pkg::ALU_W-1:0] cmp_b,
  output logic [sofa_pkg::ALU_W-1:0] sum,
  output logic                       ge
);
  import sofa_pkg::*;

  assign sum = add_a + add_b;
  assign ge  = (cmp_a >= cmp_b);

endmodule
`default_nettype wire

// ===== rtl/sofa_seq.sv =====
// Window sequencer: sample intake, reject counting and the averaging pass.
`default_nettype none
module sofa_seq (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         in_valid,
  input  wire  [11:0]                 adc_sample,
  output logic                        in_stall,
  input  wire  sofa_pkg::cfg_t        cfg,
  input  wire                         slot_free,
  output logic                        res_load,
  output sofa_pkg::res_t              res,
  output logic                        ram_we,
  output logic [sofa_pkg::IDX_W-1:0]  ram_waddr,
  output logic [7:0]                  ram_wdata,
  output logic [sofa_pkg::IDX_W-1:0]  ram_raddr,
  input  wire  [7:0]                  ram_rdata
);
  import sofa_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_PREP, S_PASS, S_EMIT} state_t;

  state_t            state;
  logic [IDX_W-1:0]  good_count;
  logic [REJ_W-1:0]  reject_count;
  logic [SUM_W-1:0]  running_sum;
  logic [SUM_W-1:0]  total;
  logic [7:0]        mean;
  logic [8:0]        limit;
  logic [IDX_W-1:0]  ptr;
  res_t              pend;

  logic [7:0]        scaled;
  logic              accept;
  logic [ALU_W-1:0]  add_a, add_b, cmp_a, cmp_b, alu_sum;
  logic              ge;
  logic [7:0]        keep;
  logic [REJ_W-1:0]  rej_inc;
  logic              rej_fail;
  logic              fail_now, done_now;
  logic [7:0]        mean_next;
  logic [SUM_W-1:0]  total_next;
  logic [7:0]        avg;
  res_t              cand;

  sofa_alu u_alu (
    .add_a (add_a),
    .add_b (add_b),
    .cmp_a (cmp_a),
    .cmp_b (cmp_b),
    .sum   (alu_sum),
    .ge    (ge)
  );

  assign scaled   = adc_sample[11:4];
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && (state == S_IDLE);

  always_comb begin
    if (state == S_PASS) begin
      cmp_a = ALU_W'(ram_rdata);
      cmp_b = ALU_W'(limit);
      add_a = ALU_W'(total);
      add_b = ALU_W'(keep);
    end else begin
      cmp_a = ALU_W'(scaled);
      cmp_b = ALU_W'(cfg.max_valid);
      add_a = ALU_W'(running_sum);
      add_b = ALU_W'(scaled);
    end
  end

  // values at or above the limit are clamped to the mean
  assign keep       = ge ? mean : ram_rdata;
  assign rej_inc    = reject_count + 1'b1;
  assign rej_fail   = (rej_inc > {1'b0, cfg.max_rejects});
  assign fail_now   = accept && ge && rej_fail;
  assign done_now   = (state == S_PASS) && (ptr == IDX_W'(SAMPLES - 1));
  assign mean_next  = 8'(running_sum / SAMPLES);
  assign total_next = SUM_W'(alu_sum);
  assign avg        = 8'(total_next / SAMPLES);

  always_comb begin
    if (state == S_EMIT) begin
      cand = pend;
    end else if (fail_now) begin
      cand = '{altitude: FAIL_ALTITUDE, failed: 1'b1};
    end else begin
      cand = '{altitude: avg, failed: 1'b0};
    end
  end

  assign res      = cand;
  assign res_load = (fail_now || done_now || (state == S_EMIT)) && slot_free;

  assign ram_we    = accept && !ge;
  assign ram_waddr = good_count;
  assign ram_wdata = scaled;
  assign ram_raddr = (state == S_PASS) ? IDX_W'(ptr + 1'b1) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      good_count   <= '0;
      reject_count <= '0;
      running_sum  <= '0;
      ptr          <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (ge) begin
              if (rej_fail) begin
                good_count   <= '0;
                reject_count <= '0;
                running_sum  <= '0;
                if (!slot_free) begin
                  pend  <= cand;
                  state <= S_EMIT;
                end
              end else begin
                reject_count <= rej_inc;
              end
            end else begin
              running_sum <= SUM_W'(alu_sum);
              good_count  <= good_count + 1'b1;
              if (good_count == IDX_W'(SAMPLES - 1)) begin
                state <= S_PREP;
              end
            end
          end
        end
        S_PREP: begin
          mean  <= mean_next;
          limit <= {1'b0, mean_next} + {1'b0, cfg.outlier_offset};
          total <= '0;
          ptr   <= '0;
          state <= S_PASS;
        end
        S_PASS: begin
          total <= total_next;
          ptr   <= ptr + 1'b1;
          if (done_now) begin
            good_count   <= '0;
            reject_count <= '0;
            running_sum  <= '0;
            if (slot_free) begin
              state <= S_IDLE;
            end else begin
              pend  <= cand;
              state <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sofa_checker.sv =====
// Port-level checks for the outlier-rejecting average filter, bound to the top.
`default_nettype none
`include "sonar_outlier_average_filter_macros.svh"
module sofa_checker (
  input wire       clk,
  input wire       rst,
  input wire       in_valid,
  input wire       in_stall,
  input wire       out_valid,
  input wire       out_stall,
  input wire [7:0] altitude,
  input wire       failed
);

  `SOFA_ASSERT(fail_alt_a, out_valid && failed |-> altitude == 8'hFF, "failure item without altitude 255")
  `SOFA_ASSERT(out_hold_a, out_valid && out_stall |=> out_valid && $stable(altitude) && $stable(failed), "stalled result changed")
  `SOFA_ASSERT(out_cause_a, $rose(out_valid) |-> $past(in_valid && !in_stall) || $past(in_stall), "result without an item or a pass")
  `SOFA_ASSERT_ALWAYS(rst_clr_a, rst |=> !out_valid, "result valid after reset")

endmodule

bind sonar_outlier_average_filter sofa_checker u_sofa_checker (.*);
`default_nettype wire
